// File: hdl/kvst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvst_pkg
// Shared sizes, operation codes and the types passed between the slot cells
// and the table controller.
// ----------------------------------------------------------------------------
package kvst_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int CAP_W     = 5;
  // high-water mark counts 0 .. MAX_SLOTS
  localparam int HW_W      = $clog2(MAX_SLOTS + 1);
  // list rotation step counter
  localparam int CNT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  // width for comparing the mark against the capacity register
  localparam int CMP_W     = (HW_W > CAP_W) ? HW_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_LIST   = 2'd3
  } func_e;

  // command broadcast to every cell
  typedef struct packed {
    logic             add;     // add with a non-null key is executing
    logic             remove;  // remove is executing
    logic             any_hit; // some slot below the mark holds the key
    logic             append;  // write the slot at the mark
    logic             shift;   // rotate the ring by one slot
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } kvst_cmd_t;

  // priority link handed from cell to cell
  typedef struct packed {
    logic             hit;     // a matching slot was seen earlier in the row
    logic             empty;   // an empty slot was seen earlier in the row
    logic [VAL_W-1:0] value;   // value of the first matching slot
  } kvst_link_t;

endpackage

// File: hdl/kvst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvst_cell
// One key/value slot: compares its key with the command key, takes part in
// the first-hit / first-empty priority chain, and rotates to its neighbor
// while the table is being listed.
// ----------------------------------------------------------------------------
module kvst_cell
  import kvst_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kvst_pkg::kvst_cmd_t        cmd_i,
  input  logic                       below_i,
  input  logic                       at_mark_i,
  input  kvst_pkg::kvst_link_t       link_i,
  output kvst_pkg::kvst_link_t       link_o,
  input  logic [kvst_pkg::KEY_W-1:0] nb_key_i,
  input  logic [kvst_pkg::VAL_W-1:0] nb_value_i,
  output logic [kvst_pkg::KEY_W-1:0] key_o,
  output logic [kvst_pkg::VAL_W-1:0] value_o,
  output logic                       live_o
);

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic             match;
  logic             empty;
  logic             hit_first;
  logic             empty_first;

  // local compare and priority
  assign match       = below_i && (key_q == cmd_i.key) && (cmd_i.key != '0);
  assign empty       = below_i && (key_q == '0);
  assign hit_first   = match && !link_i.hit;
  assign empty_first = empty && !link_i.empty;

  assign link_o.hit   = link_i.hit | match;
  assign link_o.empty = link_i.empty | empty;
  assign link_o.value = hit_first ? value_q : link_i.value;

  assign key_o   = key_q;
  assign value_o = value_q;
  assign live_o  = below_i && (key_q != '0);

  // slot storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      value_q <= '0;
    end else if (cmd_i.shift) begin
      key_q   <= nb_key_i;
      value_q <= nb_value_i;
    end else if (cmd_i.add && hit_first) begin
      value_q <= cmd_i.value;
    end else if (cmd_i.add && !cmd_i.any_hit && empty_first) begin
      key_q   <= cmd_i.key;
      value_q <= cmd_i.value;
    end else if (cmd_i.append && at_mark_i) begin
      key_q   <= cmd_i.key;
      value_q <= cmd_i.value;
    end else if (cmd_i.remove && hit_first) begin
      key_q   <= '0;
      value_q <= '0;
    end
  end

endmodule

// File: hdl/key_value_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_slot_table
// Fixed-capacity key/value table built as a ring of slot cells with a
// high-water mark; add, find, remove and list operations.
// ----------------------------------------------------------------------------
// Add, find and remove pass through the execute state, in which every slot
// compares its key in parallel and the first-hit / first-empty chain
// resolves; then the result strobes on done_o for one cycle while busy_o
// is already low again. List rotates the whole ring of MAX_SLOTS cells past
// slot 0, one slot per cycle, keeps the block busy while the ring rotates
// and strobes one result per live slot as it passes (an empty table gives
// a single miss result). Results cannot be held off by the receiver; take
// each one in the cycle done_o is high. Write capacity only while busy_o
// is low and no result is pending.
module key_value_slot_table
  import kvst_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kvst_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [kvst_pkg::FUNC_W-1:0] func_i,
  input  logic [kvst_pkg::KEY_W-1:0]  key_i,
  input  logic [kvst_pkg::VAL_W-1:0]  value_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [kvst_pkg::KEY_W-1:0]  out_key_o,
  output logic [kvst_pkg::VAL_W-1:0]  out_value_o,
  output logic                        last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_e;

  state_e              state_q;
  logic [CAP_W-1:0]    cap_q;
  logic [HW_W-1:0]     hw_q;
  logic [FUNC_W-1:0]   func_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    value_q;
  logic [MAX_SLOTS-1:0] mask_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                done_q;
  logic                ok_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [VAL_W-1:0]    out_value_q;
  logic                last_q;

  kvst_cmd_t            cmd;
  kvst_link_t           link [MAX_SLOTS+1];
  logic [KEY_W-1:0]     cell_key   [MAX_SLOTS];
  logic [VAL_W-1:0]     cell_value [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] live;
  logic [MAX_SLOTS-1:0] below;
  logic [MAX_SLOTS-1:0] at_mark;
  logic                 accept;
  logic                 exec;
  logic                 null_key;
  logic                 room;
  logic                 add_ok;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign exec     = (state_q == ST_EXEC);
  assign null_key = (key_q == '0);
  assign busy_o   = (state_q != ST_IDLE);

  // append room: mark below built size and below the capacity register
  assign room = (hw_q < HW_W'(MAX_SLOTS)) && (CMP_W'(hw_q) < CMP_W'(cap_q));

  // command broadcast to the cells
  assign cmd.add     = exec && (func_q == FUNC_ADD) && !null_key;
  assign cmd.remove  = exec && (func_q == FUNC_REMOVE);
  assign cmd.any_hit = link[MAX_SLOTS].hit;
  assign cmd.append  = cmd.add && !link[MAX_SLOTS].hit && !link[MAX_SLOTS].empty && room;
  assign cmd.shift   = (state_q == ST_LIST);
  assign cmd.key     = key_q;
  assign cmd.value   = value_q;

  assign add_ok = !null_key && (link[MAX_SLOTS].hit || link[MAX_SLOTS].empty || room);

  assign link[0] = '0;

  // ring of slot cells, slot i takes from slot i+1 on rotation
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    assign below[i]   = HW_W'(i) < hw_q;
    assign at_mark[i] = hw_q == HW_W'(i);

    kvst_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .below_i    (below[i]),
      .at_mark_i  (at_mark[i]),
      .link_i     (link[i]),
      .link_o     (link[i+1]),
      .nb_key_i   (cell_key[(i + 1) % MAX_SLOTS]),
      .nb_value_i (cell_value[(i + 1) % MAX_SLOTS]),
      .key_o      (cell_key[i]),
      .value_o    (cell_value[i]),
      .live_o     (live[i])
    );
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // operation sequencer, mark and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hw_q        <= '0;
      func_q      <= '0;
      key_q       <= '0;
      value_q     <= '0;
      mask_q      <= '0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      ok_q        <= 1'b0;
      out_key_q   <= '0;
      out_value_q <= '0;
      last_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q  <= func_i;
            key_q   <= key_i;
            value_q <= value_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q     <= ST_IDLE;
          out_key_q   <= key_q;
          out_value_q <= '0;
          last_q      <= 1'b1;
          case (func_q)
            FUNC_ADD: begin
              done_q <= 1'b1;
              ok_q   <= add_ok;
              if (cmd.append) begin
                hw_q <= hw_q + HW_W'(1);
              end
            end
            FUNC_FIND: begin
              done_q      <= 1'b1;
              ok_q        <= link[MAX_SLOTS].hit;
              out_value_q <= link[MAX_SLOTS].value;
            end
            FUNC_REMOVE: begin
              done_q <= 1'b1;
              ok_q   <= link[MAX_SLOTS].hit;
            end
            default: begin
              // list: an empty table answers with one miss
              if (live == '0) begin
                done_q    <= 1'b1;
                ok_q      <= 1'b0;
                out_key_q <= '0;
              end else begin
                mask_q  <= live;
                cnt_q   <= '0;
                state_q <= ST_LIST;
              end
            end
          endcase
        end
        ST_LIST: begin
          // slot cnt_q sits in cell 0 this cycle
          done_q      <= mask_q[0];
          ok_q        <= 1'b1;
          out_key_q   <= cell_key[0];
          out_value_q <= cell_value[0];
          last_q      <= (mask_q >> 1) == '0;
          mask_q      <= mask_q >> 1;
          cnt_q       <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(MAX_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign out_key_o   = out_key_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

  // a transaction that is not the last of its item keeps the block busy
  a_more_results_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> busy_o)
    else $error("non-final result while block is idle");

  // the high-water mark never goes down
  a_mark_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q >= $past(hw_q))
    else $error("high-water mark decreased");

  // the mark never passes the built slot count
  a_mark_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= HW_W'(MAX_SLOTS))
    else $error("high-water mark beyond slot count");

  // an accepted item always makes the block busy next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not start");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key/value slot table. A behavioral copy of the
// table predicts every result transaction of add, find, remove and list;
// directed commands hit the corner cases, then random phases run with
// different capacity settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  import kvst_pkg::*;

  localparam int POOL_SIZE = 24;
  localparam int SETTLE_CYCLES = MAX_SLOTS + 4;

  typedef struct {
    logic             ok;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             last;
  } table_result_t;

  // behavioral copy of the table plus the queue of results it predicts
  class slot_table_model;
    logic [KEY_W-1:0] slot_key [MAX_SLOTS];
    logic [VAL_W-1:0] slot_val [MAX_SLOTS];
    int               mark;
    int               capacity;
    table_result_t    pending_results[$];
    int               mismatches;

    function new();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      mark = 0;
      capacity = int'(CAP_RESET);
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = int'(cap);
    endfunction

    function void push_result(logic ok, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                              logic last);
      table_result_t r;
      r.ok = ok;
      r.key = k;
      r.value = v;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    // apply one accepted command and queue the results it causes
    function void accept_command(func_e f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int hit;
      int hole;
      int usable;
      int last_live;
      hit = -1;
      hole = -1;
      last_live = -1;
      usable = (capacity > MAX_SLOTS) ? MAX_SLOTS : capacity;
      for (int i = 0; i < mark; i++) begin
        if (hit < 0 && slot_key[i] == k) hit = i;
        if (hole < 0 && slot_key[i] == '0) hole = i;
        if (slot_key[i] != '0) last_live = i;
      end
      case (f)
        FUNC_ADD: begin
          if (k == '0) begin
            push_result(1'b0, k, '0, 1'b1);
          end else if (hit >= 0) begin
            slot_val[hit] = v;
            push_result(1'b1, k, '0, 1'b1);
          end else if (hole >= 0) begin
            slot_key[hole] = k;
            slot_val[hole] = v;
            push_result(1'b1, k, '0, 1'b1);
          end else if (mark < usable) begin
            slot_key[mark] = k;
            slot_val[mark] = v;
            mark++;
            push_result(1'b1, k, '0, 1'b1);
          end else begin
            push_result(1'b0, k, '0, 1'b1);
          end
        end
        FUNC_FIND: begin
          if (k != '0 && hit >= 0) push_result(1'b1, k, slot_val[hit], 1'b1);
          else push_result(1'b0, k, '0, 1'b1);
        end
        FUNC_REMOVE: begin
          if (k != '0 && hit >= 0) begin
            slot_key[hit] = '0;
            slot_val[hit] = '0;
            push_result(1'b1, k, '0, 1'b1);
          end else begin
            push_result(1'b0, k, '0, 1'b1);
          end
        end
        default: begin
          // list every live slot below the mark, or one miss if none
          if (last_live < 0) begin
            push_result(1'b0, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i <= last_live; i++) begin
              if (slot_key[i] != '0)
                push_result(1'b1, slot_key[i], slot_val[i], i == last_live);
            end
          end
        end
      endcase
    endfunction

    // compare one result transaction with the oldest prediction
    function void compare_result(logic ok, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                 logic last);
      table_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: ok=%0d key=%h value=%h last=%0d", ok, k, v, last);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      if (ok !== e.ok) begin
        $error("ok: expected %0d, got %0d", e.ok, ok);
        mismatches++;
      end
      if (k !== e.key) begin
        $error("out_key: expected %h, got %h", e.key, k);
        mismatches++;
      end
      if (v !== e.value) begin
        $error("out_value: expected %h, got %h", e.value, v);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CAP_W-1:0]  cfg_wdata_i;
  logic              start_i;
  logic              busy_o;
  logic [FUNC_W-1:0] func_i;
  logic [KEY_W-1:0]  key_i;
  logic [VAL_W-1:0]  value_i;
  logic              done_o;
  logic              ok_o;
  logic [KEY_W-1:0]  out_key_o;
  logic [VAL_W-1:0]  out_value_o;
  logic              last_o;

  slot_table_model   table_model = new();
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  key_value_slot_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .ok_o        (ok_o),
    .out_key_o   (out_key_o),
    .out_value_o (out_value_o),
    .last_o      (last_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result transactions are taken every cycle done_o is high
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      table_model.compare_result(ok_o, out_key_o, out_value_o, last_o);
  end

  // hold start high with the command until a rising edge sees busy low;
  // start stays high on return so back-to-back commands need no toggle
  task automatic issue_command(func_e f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                               int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i  <= f;
    key_i   <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    table_model.accept_command(f, k, v);
  endtask

  // wait until every predicted result has arrived and the list walk is over
  task automatic drain_results();
    start_i <= 1'b0;
    while (table_model.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    table_model.set_capacity(cap);
  endtask

  // random command mostly over a small key pool so that hits are common
  task automatic issue_random_command(int idle_pct);
    int               pick;
    func_e            f;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 40) f = FUNC_ADD;
    else if (pick < 65) f = FUNC_FIND;
    else if (pick < 85) f = FUNC_REMOVE;
    else f = FUNC_LIST;
    pick = $urandom_range(99);
    if (pick < 5) k = '0;
    else if (pick < 15) k = $urandom;
    else k = key_pool[$urandom_range(POOL_SIZE - 1)];
    v = ($urandom_range(9) == 0) ? '0 : VAL_W'($urandom);
    issue_command(f, k, v, idle_pct);
  endtask

  initial begin
    int phase_cap  [6];
    int phase_idle [6];
    phase_cap  = '{0, 5, 1, 31, 16, 8};
    phase_idle = '{0, 60, 29, 0, 60, 29};

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    func_i      = FUNC_ADD;
    key_i       = '0;
    value_i     = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0) key_pool[i] = 32'h1;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: null keys, extremes, zero value, holes, full table
    write_capacity(CAP_W'(3));
    issue_command(FUNC_LIST,   32'h0,        32'h1234_5678, 0);
    issue_command(FUNC_ADD,    32'h0,        32'hFFFF_FFFF, 0);
    issue_command(FUNC_REMOVE, 32'h0,        32'h0,         0);
    issue_command(FUNC_FIND,   32'h0,        32'h0,         0);
    issue_command(FUNC_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    issue_command(FUNC_ADD,    32'h1,        32'h0,         0);
    issue_command(FUNC_FIND,   32'h1,        32'hFFFF_FFFF, 0);
    issue_command(FUNC_FIND,   32'hFFFF_FFFF, 32'h0,        0);
    issue_command(FUNC_ADD,    32'h1,        32'h5A5A_A5A5, 0);
    issue_command(FUNC_FIND,   32'h2,        32'h0,         0);
    issue_command(FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0,        0);
    issue_command(FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0,        0);
    issue_command(FUNC_LIST,   32'h0,        32'h0,         0);
    issue_command(FUNC_ADD,    32'h2,        32'h7,         0);
    issue_command(FUNC_ADD,    32'h3,        32'h8,         0);
    issue_command(FUNC_ADD,    32'h4,        32'h9,         0);
    issue_command(FUNC_LIST,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    issue_command(FUNC_REMOVE, 32'h4,        32'h0,         0);

    // capacity below the mark: holes still fill, appends are refused
    write_capacity(CAP_W'(1));
    issue_command(FUNC_ADD,    32'h5,        32'hA,         0);
    issue_command(FUNC_REMOVE, 32'h2,        32'h0,         0);
    issue_command(FUNC_ADD,    32'h5,        32'hB,         0);
    issue_command(FUNC_ADD,    32'h6,        32'hC,         0);
    issue_command(FUNC_LIST,   32'h0,        32'h0,         0);

    // random phases, each with its own capacity and idle rate
    for (int p = 0; p < 6; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      repeat (85) issue_random_command(phase_idle[p]);
    end

    drain_results();
    if (table_model.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
hdl/kvst_pkg.sv
hdl/kvst_cell.sv
hdl/key_value_slot_table.sv
bench/tb_top.sv
